[rtl/gsdp_pkg.sv]
`default_nettype none
package gsdp_pkg;
    localparam int MAX_NODES  = 64;
    localparam int MAX_DEGREE = 64;
    localparam int ID_W   = 7;
    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int DIDX_W = $clog2(MAX_DEGREE);
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int SP_W   = $clog2(MAX_NODES + 1);

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_REDUNDANT = 3'd2;
    localparam logic [2:0] ST_PATH      = 3'd3;
    localparam logic [2:0] ST_NOPATH    = 3'd4;
    localparam logic [2:0] ST_BADIDS    = 3'd5;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] from_node;
        logic [ID_W-1:0] to_node;
    } in_word_t;

    typedef struct packed {
        logic [2:0]      status;
        logic [ID_W-1:0] path_node;
        logic            last;
    } out_word_t;
endpackage
`default_nettype wire

[rtl/graph_store_dfs_path.sv]
// add-edge reads the degree, then checks the stored neighbors in turn before it answers,
// sooner on a repeated edge; bad ids answer on the next cycle; search clears the marks,
// pops and scans each node's neighbors, then reads a parent before each path word
// throughput: one word at a time; the next word waits until the last result is taken
// reset: rst_n async low clears node_count and control, then a pass zeroes the
// degree list before the first word is taken; the neighbor store is not cleared
`default_nettype none
module graph_store_dfs_path (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [6:0]           cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire gsdp_pkg::in_word_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output gsdp_pkg::out_word_t       out_data
);
    import gsdp_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DEG, S_DUP_RD, S_DUP_CMP, S_CLR, S_POP, S_POP_CHK, S_NB_LEN,
        S_NB_RD, S_NB_VIS, S_NB_CHK, S_PATH, S_OUT
    } state_t;

    state_t              state_reg;
    logic [6:0]          ncount_reg;
    logic [ID_W-1:0]     live;
    logic                kind_reg;
    logic [ID_W-1:0]     a_reg, b_reg, cur_reg, pnode_reg;
    logic [DEG_W-1:0]    k_reg, len_reg;
    logic [SP_W-1:0]     sp_reg;
    logic [IDX_W:0]      clr_reg;
    logic [SP_W-1:0]     cnt_reg;
    logic                path_mode_reg;
    out_word_t           out_reg;
    logic                ov_reg;

    logic [DEG_W-1:0]    degree_mem [MAX_NODES];
    logic                visit_mem  [MAX_NODES];
    logic [ID_W-1:0]     parent_mem [MAX_NODES];
    logic [ID_W-1:0]     stack_mem  [MAX_NODES];
    logic [ID_W-1:0]     nb_mem     [MAX_NODES*MAX_DEGREE];
    logic [ID_W-1:0]     nb_rd, stack_rd, parent_rd;
    logic [DEG_W-1:0]    deg_rd;
    logic                visit_rd;

    // clamp node count
    assign live = (ncount_reg > 7'(MAX_NODES)) ? 7'(MAX_NODES) : ncount_reg;

    function automatic logic id_ok(input logic [ID_W-1:0] id, input logic [ID_W-1:0] n);
        return (id != '0) && (id <= n);
    endfunction

    logic [IDX_W-1:0] ai, ci;
    assign ai = IDX_W'(a_reg - 7'd1);
    assign ci = IDX_W'(cur_reg - 7'd1);

    // neighbor store: one write, one registered read
    logic [IDX_W+DIDX_W-1:0] nb_waddr, nb_raddr;
    assign nb_waddr = {ai, DIDX_W'(len_reg)};
    assign nb_raddr = (kind_reg == KIND_ADD) ? {ai, DIDX_W'(k_reg)} : {ci, DIDX_W'(k_reg)};
    logic nb_wr_en;
    assign nb_wr_en = (state_reg == S_DUP_CMP) && (k_reg == len_reg) &&
                      (len_reg < DEG_W'(MAX_DEGREE));
    always_ff @(posedge clk)
    begin
        if (nb_wr_en)
            nb_mem[nb_waddr] <= b_reg;
        nb_rd <= nb_mem[nb_raddr];
    end

    // degree list: cleared after reset, one write, one registered read
    logic             deg_we;
    logic [IDX_W-1:0] deg_waddr, deg_raddr;
    logic [DEG_W-1:0] deg_wdata;
    always_comb
    begin
        deg_we    = 1'b0;
        deg_waddr = IDX_W'(clr_reg);
        deg_wdata = '0;
        if (state_reg == S_INIT)
            deg_we = 1'b1;
        else if (nb_wr_en)
        begin
            deg_we    = 1'b1;
            deg_waddr = ai;
            deg_wdata = len_reg + DEG_W'(1);
        end
    end
    assign deg_raddr = (state_reg == S_IDLE) ? IDX_W'(in_data.from_node - 7'd1) :
                                               IDX_W'(stack_rd - 7'd1);
    always_ff @(posedge clk)
    begin
        if (deg_we)
            degree_mem[deg_waddr] <= deg_wdata;
        deg_rd <= degree_mem[deg_raddr];
    end

    // stack, parent and visit memories
    logic stk_we, par_we, vis_we, vis_wdata;
    logic [IDX_W-1:0] stk_waddr, stk_raddr, par_addr, vis_waddr, vis_raddr;
    logic [ID_W-1:0]  stk_wdata;
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[stk_waddr] <= stk_wdata;
        stack_rd <= stack_mem[stk_raddr];
        if (par_we)
            parent_mem[IDX_W'(nb_rd - 7'd1)] <= cur_reg;
        parent_rd <= parent_mem[par_addr];
        if (vis_we)
            visit_mem[vis_waddr] <= vis_wdata;
        visit_rd <= visit_mem[vis_raddr];
    end
    assign stk_raddr = IDX_W'(sp_reg - SP_W'(1));
    assign par_addr  = (state_reg == S_PATH) ? IDX_W'(pnode_reg - 7'd1) : '0;
    assign vis_raddr = IDX_W'(nb_rd - 7'd1);

    logic nb_push_ok;
    assign nb_push_ok = id_ok(nb_rd, live) && !visit_rd && (sp_reg < SP_W'(MAX_NODES));
    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = IDX_W'(sp_reg);
        stk_wdata = nb_rd;
        par_we    = 1'b0;
        vis_we    = 1'b0;
        vis_waddr = IDX_W'(clr_reg);
        vis_wdata = 1'b0;
        if (state_reg == S_CLR && clr_reg == (IDX_W+1)'(MAX_NODES))
        begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = a_reg;
            vis_we    = 1'b1;
            vis_waddr = ai;
            vis_wdata = 1'b1;
        end
        else if (state_reg == S_CLR)
            vis_we = 1'b1;
        else if (state_reg == S_NB_CHK && nb_push_ok)
        begin
            stk_we    = 1'b1;
            par_we    = 1'b1;
            vis_we    = 1'b1;
            vis_waddr = vis_raddr;
            vis_wdata = 1'b1;
        end
    end

    // path word emission
    logic path_emit, path_fin;
    assign path_emit = (state_reg == S_PATH) && path_mode_reg && (!ov_reg || !out_stall);
    assign path_fin  = (pnode_reg == a_reg) || (7'(cnt_reg) + 7'd1 >= live);

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            ncount_reg    <= '0;
            ov_reg        <= 1'b0;
            sp_reg        <= '0;
            clr_reg       <= '0;
            path_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                ncount_reg <= cfg_wdata;
            if (ov_reg && !out_stall && !path_emit)
                ov_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    if (clr_reg == (IDX_W+1)'(MAX_NODES - 1))
                        state_reg <= S_IDLE;
                    clr_reg <= clr_reg + (IDX_W+1)'(1);
                end
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        kind_reg <= in_data.kind;
                        a_reg    <= in_data.from_node;
                        b_reg    <= in_data.to_node;
                        k_reg    <= '0;
                        if (!id_ok(in_data.from_node, live) || !id_ok(in_data.to_node, live))
                        begin
                            out_reg <= '{(in_data.kind == KIND_ADD) ? ST_INVALID : ST_BADIDS,
                                         '0, 1'b1};
                            ov_reg  <= 1'b1;
                        end
                        else if (in_data.kind == KIND_ADD)
                            state_reg <= S_DEG;
                        else
                        begin
                            clr_reg   <= '0;
                            state_reg <= S_CLR;
                        end
                    end
                end
                S_DEG:
                begin
                    len_reg   <= deg_rd;
                    state_reg <= S_DUP_RD;
                end
                S_DUP_RD: state_reg <= S_DUP_CMP;
                S_DUP_CMP:
                begin
                    if (k_reg != len_reg && nb_rd == b_reg)
                    begin
                        out_reg <= '{ST_REDUNDANT, '0, 1'b1};
                        state_reg <= S_OUT;
                    end
                    else if (k_reg == len_reg)
                    begin
                        if (len_reg < DEG_W'(MAX_DEGREE))
                            out_reg <= '{ST_ADDED, '0, 1'b1};
                        else
                            out_reg <= '{ST_INVALID, '0, 1'b1};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        k_reg <= k_reg + DEG_W'(1);
                        state_reg <= S_DUP_RD;
                    end
                end
                S_CLR:
                begin
                    if (clr_reg == (IDX_W+1)'(MAX_NODES))
                    begin
                        sp_reg        <= SP_W'(1);
                        state_reg     <= S_POP;
                    end
                    else
                        clr_reg <= clr_reg + (IDX_W+1)'(1);
                end
                S_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        out_reg   <= '{ST_NOPATH, '0, 1'b1};
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_POP_CHK;
                end
                S_POP_CHK:
                begin
                    sp_reg  <= sp_reg - SP_W'(1);
                    cur_reg <= stack_rd;
                    k_reg   <= '0;
                    if (stack_rd == b_reg)
                    begin
                        pnode_reg <= stack_rd;
                        cnt_reg   <= '0;
                        path_mode_reg <= 1'b0;
                        state_reg <= S_PATH;
                    end
                    else
                        state_reg <= S_NB_LEN;
                end
                S_NB_LEN:
                begin
                    len_reg   <= deg_rd;
                    state_reg <= S_NB_RD;
                end
                S_NB_RD:
                begin
                    if (k_reg == len_reg)
                        state_reg <= S_POP;
                    else
                        state_reg <= S_NB_VIS;
                end
                S_NB_VIS: state_reg <= S_NB_CHK;
                S_NB_CHK:
                begin
                    if (nb_push_ok)
                        sp_reg <= sp_reg + SP_W'(1);
                    k_reg     <= k_reg + DEG_W'(1);
                    state_reg <= S_NB_RD;
                end
                S_PATH:
                begin
                    // reads the parent first, then emits once the output is free
                    if (!path_mode_reg)
                        path_mode_reg <= 1'b1;
                    else if (path_emit)
                    begin
                        out_reg <= '{ST_PATH, pnode_reg, path_fin};
                        ov_reg  <= 1'b1;
                        cnt_reg <= cnt_reg + SP_W'(1);
                        pnode_reg <= parent_rd;
                        path_mode_reg <= 1'b0;
                        if (path_fin)
                        begin
                            sp_reg    <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!ov_reg)
                    begin
                        ov_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(MAX_NODES)) else $error("stack overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("ready while busy");
    a_path_status: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_reg.status != ST_PATH) |-> out_reg.last) else $error("last missing");
endmodule
`default_nettype wire

[verif/graph_store_dfs_path_tb.sv]
`default_nettype none
module graph_store_dfs_path_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gsdp_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 200;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [6:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    in_word_t in_data;
    logic out_valid;
    logic out_stall;
    out_word_t out_data;

    graph_store_dfs_path dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // graph shadow
    logic [6:0] adj [MAX_NODES][MAX_DEGREE];
    int deg [MAX_NODES];
    int node_limit;
    out_word_t expected_words[$];
    int mismatches;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int live_nodes();
        return node_limit > MAX_NODES ? MAX_NODES : node_limit;
    endfunction

    function automatic bit id_ok(int id);
        return id >= 1 && id <= live_nodes();
    endfunction

    function automatic out_word_t mk_word(logic [2:0] st, int node, bit lst);
        out_word_t w;
        w.status = st;
        w.path_node = node[6:0];
        w.last = lst;
        return w;
    endfunction

    // edge insert prediction
    task automatic predict_add(int src, int dst);
        int s;
        if (!id_ok(src) || !id_ok(dst))
        begin
            expected_words.push_back(mk_word(ST_INVALID, 0, 1'b1));
            return;
        end
        s = src - 1;
        for (int k = 0; k < deg[s]; k++)
            if (adj[s][k] == dst)
            begin
                expected_words.push_back(mk_word(ST_REDUNDANT, 0, 1'b1));
                return;
            end
        if (deg[s] >= MAX_DEGREE)
        begin
            expected_words.push_back(mk_word(ST_INVALID, 0, 1'b1));
            return;
        end
        adj[s][deg[s]] = dst[6:0];
        deg[s]++;
        expected_words.push_back(mk_word(ST_ADDED, 0, 1'b1));
    endtask

    // depth-first path prediction, marks set at push
    task automatic predict_search(int start, int goal);
        bit seen [MAX_NODES];
        int par [MAX_NODES];
        int stk [$];
        int n;
        int cur;
        int nb;
        int cnt;
        int node;
        bit fin;
        n = live_nodes();
        if (!id_ok(start) || !id_ok(goal))
        begin
            expected_words.push_back(mk_word(ST_BADIDS, 0, 1'b1));
            return;
        end
        for (int i = 0; i < MAX_NODES; i++)
        begin
            seen[i] = 0;
            par[i] = 0;
        end
        stk.push_back(start);
        seen[start-1] = 1;
        while (stk.size() > 0)
        begin
            cur = stk.pop_back();
            if (cur == goal)
            begin
                cnt = 0;
                node = cur;
                forever
                begin
                    fin = (par[node-1] == 0) || (cnt + 1 >= n);
                    expected_words.push_back(mk_word(ST_PATH, node, fin));
                    cnt++;
                    if (fin)
                        return;
                    node = par[node-1];
                end
            end
            for (int k = 0; k < deg[cur-1]; k++)
            begin
                nb = int'(adj[cur-1][k]);
                if (nb >= 1 && nb <= n && !seen[nb-1] && stk.size() < MAX_NODES)
                begin
                    stk.push_back(nb);
                    seen[nb-1] = 1;
                    par[nb-1] = cur;
                end
            end
        end
        expected_words.push_back(mk_word(ST_NOPATH, 0, 1'b1));
    endtask

    task automatic report(string what, out_word_t got, out_word_t want);
        mismatches++;
        $display("mismatch %s: got st=%0d node=%0d last=%0d want st=%0d node=%0d last=%0d",
            what, got.status, got.path_node, got.last,
            want.status, want.path_node, want.last);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one word and predict its results
    task automatic send_word(logic knd, int a, int b);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.kind <= knd;
        in_data.from_node <= a[6:0];
        in_data.to_node <= b[6:0];
        if (knd == KIND_ADD)
            predict_add(a, b);
        else
            predict_search(a, b);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_nodes(int v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v[6:0];
        node_limit = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver stall and result check
    int stall_left;
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report("unexpected", out_data, out_data);
                else
                begin
                    want = expected_words.pop_front();
                    if (out_data.status !== want.status)
                        report("status", out_data, want);
                    else if (out_data.path_node !== want.path_node)
                        report("path_node", out_data, want);
                    else if (out_data.last !== want.last)
                        report("last", out_data, want);
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left <= gap_len();
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic test_directed();
        set_nodes(0);
        send_word(KIND_ADD, 1, 2);
        send_word(KIND_SEARCH, 1, 1);
        set_nodes(64);
        send_word(KIND_ADD, 0, 5);
        send_word(KIND_ADD, 5, 0);
        send_word(KIND_ADD, 65, 1);
        send_word(KIND_ADD, 127, 127);
        send_word(KIND_ADD, 1, 2);
        send_word(KIND_ADD, 1, 2);
        send_word(KIND_ADD, 2, 3);
        send_word(KIND_ADD, 1, 64);
        send_word(KIND_ADD, 64, 3);
        send_word(KIND_SEARCH, 1, 3);
        send_word(KIND_SEARCH, 3, 1);
        send_word(KIND_SEARCH, 7, 7);
        send_word(KIND_SEARCH, 0, 3);
        send_word(KIND_SEARCH, 1, 127);
        set_nodes(127);
        send_word(KIND_SEARCH, 1, 64);
        send_word(KIND_SEARCH, 64, 65);
    endtask

    task automatic test_full_list();
        set_nodes(64);
        for (int i = 1; i <= 64; i++)
            if (i != 2 && i != 64)
                send_word(KIND_ADD, 1, i);
        send_word(KIND_ADD, 1, 10);
        for (int i = 1; i <= 64; i++)
            send_word(KIND_ADD, 4, i);
        send_word(KIND_ADD, 4, 5);
        // long chain for a deep path
        for (int i = 10; i < 64; i++)
            send_word(KIND_ADD, i, i + 1);
        send_word(KIND_SEARCH, 10, 64);
        send_word(KIND_SEARCH, 4, 64);
    endtask

    task automatic test_lowered_count();
        set_nodes(12);
        send_word(KIND_SEARCH, 10, 12);
        send_word(KIND_SEARCH, 1, 3);
        send_word(KIND_SEARCH, 4, 11);
        send_word(KIND_ADD, 1, 13);
        set_nodes(2);
        send_word(KIND_SEARCH, 1, 2);
        send_word(KIND_SEARCH, 2, 1);
    endtask

    task automatic test_random();
        int sizes [4] = '{8, 16, 64, 100};
        int n;
        int r;
        for (int ph = 0; ph < 4; ph++)
        begin
            set_nodes(sizes[ph]);
            n = sizes[ph] > 64 ? 64 : sizes[ph];
            for (int i = 0; i < 6; i++)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    send_word(KIND_ADD, $urandom_range(1, n), $urandom_range(1, n));
                else if (r < 9)
                    send_word(KIND_SEARCH, $urandom_range(1, n), $urandom_range(1, n));
                else
                    send_word(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                        $urandom_range(0, 127));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        stall_left = 0;
        mismatches = 0;
        cycles = 0;
        node_limit = 0;
        for (int i = 0; i < MAX_NODES; i++)
            deg[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_list();
        test_lowered_count();
        test_random();
        wait_idle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

[graph_store_dfs_path.f]
rtl/gsdp_pkg.sv
rtl/graph_store_dfs_path.sv
verif/graph_store_dfs_path_tb.sv
